### sv/bmlcd_pkg.sv
`default_nettype none
package bmlcd_pkg;

  localparam int MaxWidth    = 128;
  localparam int MaxHeight   = 64;
  localparam int RowBytesMax = (MaxWidth + 7) / 8;
  localparam int FrameBytes  = RowBytesMax * MaxHeight;
  localparam int StoreDepth  = 2 * FrameBytes;
  localparam int StoreAw     = $clog2(StoreDepth);
  localparam int IdxW        = $clog2(FrameBytes);
  localparam int ColW        = $clog2(MaxWidth);
  localparam int PageW       = $clog2(MaxHeight / 8);
  localparam int RowW        = $clog2(MaxHeight);

  localparam int StepsKey  = 8;
  localparam int StepsDiff = 16;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_FETCH   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DIFF   = 2'd2;

  localparam logic [7:0] WidthReset  = 8'd84;
  localparam logic [6:0] HeightReset = 7'd48;

  typedef enum logic [1:0] {
    OUT_CUR,
    OUT_HIT,
    OUT_NONE
  } out_kind_e;

  typedef struct packed {
    logic [7:0] width;
    logic [6:0] height;
    logic       diff_mode;
  } cfg_t;

  typedef struct packed {
    logic      mem_wr;
    logic      restart;
    logic      scan_init;
    logic      rd_issue;
    logic [3:0] rd_step;
    logic      scan_adv;
    logic      cursor_adv;
    logic      done_set;
    logic      hit_save;
    logic      out_load;
    out_kind_e out_kind;
    logic      out_last;
  } cmd_t;

  typedef struct packed {
    logic done_cond;
    logic differ;
    logic more;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] eff_width(logic [7:0] w);
    logic [7:0] r;
    if (w == 8'd0) begin
      r = 8'd1;
    end else if (w > 8'(MaxWidth)) begin
      r = 8'(MaxWidth);
    end else begin
      r = w;
    end
    return r;
  endfunction

  function automatic logic [6:0] eff_height(logic [6:0] h);
    logic [6:0] r;
    if (h == 7'd0) begin
      r = 7'd1;
    end else if (h > 7'(MaxHeight)) begin
      r = 7'(MaxHeight);
    end else begin
      r = h;
    end
    return r;
  endfunction

  function automatic logic [3:0] page_count(logic [6:0] h);
    logic [7:0] t;
    t = {1'b0, h} + 8'd7;
    return t[6:3];
  endfunction

  function automatic logic [4:0] row_bytes(logic [7:0] w);
    logic [8:0] t;
    t = {1'b0, w} + 9'd7;
    return t[7:3];
  endfunction

endpackage
`default_nettype wire

### sv/bitmap_to_lcd_page_bytes_with_diff.sv
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  one request: write, fetch or restart
// m_axis    out        m_axis_tvalid / m_axis_tready  one page byte or a not-found mark
// apb       in         psel, penable, pwrite, pready  width, height and diff mode
//
// A keyframe fetch makes eight reads of the single-port bitmap store, one per pixel row,
// between its start state and its wait and decide states. In diff mode each scanned address
// costs 16 store reads, over both frames, and a found byte is followed by a scan ahead
// to the next differing address to settle tlast.
// Reset clears the readout cursor and the registers; the bitmap store is not cleared.
// A waiting result holds the next fetch at its output step, and no request is taken then.
`default_nettype none
module bitmap_to_lcd_page_bytes_with_diff import bmlcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // src_index[9:0], src_byte[17:10], zero pad
  input  logic [2:0]  s_axis_tuser,  // req_type[1:0], frame_sel[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // lcd_addr[9:0], lcd_byte[17:10], zero pad
  output logic [0:0]  m_axis_tuser,  // found[0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic [9:0] lcd_addr;
  logic [7:0] lcd_byte;
  logic       found;

  assign pready = 1'b1;

  bmlcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  bmlcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser[1:0]),
    .diff_mode_i (cfg.diff_mode),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmlcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .frame_sel_i (s_axis_tuser[2]),
    .src_index_i (s_axis_tdata[9:0]),
    .src_byte_i  (s_axis_tdata[17:10]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .lcd_addr_o  (lcd_addr),
    .lcd_byte_o  (lcd_byte),
    .found_o     (found),
    .is_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, lcd_byte, lcd_addr};
  assign m_axis_tuser = found;

endmodule
`default_nettype wire

### sv/bmlcd_regs.sv
`default_nettype none
module bmlcd_regs import bmlcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg_o
);

  logic [7:0] width_q;
  logic [6:0] height_q;
  logic       diff_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      diff_q   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[7:0];
        REG_HEIGHT: height_q <= pwdata[6:0];
        REG_DIFF:   diff_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {24'd0, width_q};
      REG_HEIGHT: prdata = {25'd0, height_q};
      REG_DIFF:   prdata = {31'd0, diff_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{width: width_q, height: height_q, diff_mode: diff_q};

endmodule
`default_nettype wire

### sv/bmlcd_ctrl.sv
`default_nettype none
module bmlcd_ctrl import bmlcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic       diff_mode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_GATHER = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  localparam logic [3:0] LastKey  = 4'(StepsKey - 1);
  localparam logic [3:0] LastDiff = 4'(StepsDiff - 1);

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       look_q, look_d;
  logic       accept;
  logic [3:0] last_step;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign last_step  = diff_mode_i ? LastDiff : LastKey;

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = OUT_NONE;
    state_d        = state_q;
    step_d         = step_q;
    look_d         = look_q;
    cmd_o.mem_wr   = accept && (req_type_i == REQ_WRITE);
    cmd_o.restart  = accept && (req_type_i == REQ_RESTART);
    unique case (state_q)
      S_IDLE: begin
        if (accept && (req_type_i == REQ_FETCH)) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (sts_i.done_cond) begin
          cmd_o.done_set = 1'b1;
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = OUT_NONE;
            cmd_o.out_last = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.scan_init = 1'b1;
          look_d          = 1'b0;
          step_d          = 4'd0;
          state_d         = S_GATHER;
        end
      end
      S_GATHER: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.rd_step  = step_q;
        if (step_q == last_step) begin
          step_d  = 4'd0;
          state_d = S_WAIT;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      S_WAIT: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!diff_mode_i) begin
          if (sts_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_kind   = OUT_CUR;
            cmd_o.out_last   = !sts_i.more;
            cmd_o.cursor_adv = sts_i.more;
            cmd_o.done_set   = !sts_i.more;
            state_d          = S_IDLE;
          end
        end else if (!look_q) begin
          if (sts_i.differ && sts_i.more) begin
            cmd_o.hit_save   = 1'b1;
            cmd_o.cursor_adv = 1'b1;
            cmd_o.scan_adv   = 1'b1;
            look_d           = 1'b1;
            state_d          = S_GATHER;
          end else if (!sts_i.differ && sts_i.more) begin
            cmd_o.scan_adv = 1'b1;
            state_d        = S_GATHER;
          end else if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = sts_i.differ ? OUT_CUR : OUT_NONE;
            cmd_o.out_last = 1'b1;
            cmd_o.done_set = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          if (!sts_i.differ && sts_i.more) begin
            cmd_o.scan_adv = 1'b1;
            state_d        = S_GATHER;
          end else if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = OUT_HIT;
            cmd_o.out_last = !sts_i.differ;
            state_d        = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 4'd0;
      look_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      look_q  <= look_d;
    end
  end

endmodule
`default_nettype wire

### sv/bmlcd_dp.sv
`default_nettype none
module bmlcd_dp import bmlcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        frame_sel_i,
  input  logic [9:0]  src_index_i,
  input  logic [7:0]  src_byte_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [9:0]  lcd_addr_o,
  output logic [7:0]  lcd_byte_o,
  output logic        found_o,
  output logic        is_last_o
);

  logic [7:0]       store_q [StoreDepth];
  logic [7:0]       rdata_q;
  logic             rd_vld_q;
  logic [3:0]       rd_step_q;
  logic             rd_ok_q;
  logic [7:0]       acc0_q, acc1_q;

  logic [PageW-1:0] rd_page_q, scan_page_q;
  logic [ColW-1:0]  rd_col_q, scan_col_q;
  logic             rd_done_q;

  logic [9:0]       hit_addr_q;
  logic [7:0]       hit_byte_q;

  logic             out_valid_q;
  logic [9:0]       out_addr_q;
  logic [7:0]       out_byte_q;
  logic             out_found_q;
  logic             out_last_q;

  logic [7:0]       w;
  logic [6:0]       h;
  logic [3:0]       pc;
  logic [4:0]       rb;
  logic [7:0]       col_inc;
  logic [3:0]       page_inc;
  logic             more_col, more_page;
  logic [ColW-1:0]  nxt_col;
  logic [PageW-1:0] nxt_page;
  logic [RowW-1:0]  row;
  logic [10:0]      row_base;
  logic [10:0]      idx;
  logic [StoreAw-1:0] rd_addr, wr_addr;
  logic [10:0]      lin;
  logic [9:0]       cur_addr;
  logic [7:0]       cur_byte;
  logic             px;

  assign w  = eff_width(cfg_i.width);
  assign h  = eff_height(cfg_i.height);
  assign pc = page_count(h);
  assign rb = row_bytes(w);

  assign col_inc   = {1'b0, scan_col_q} + 8'd1;
  assign page_inc  = {1'b0, scan_page_q} + 4'd1;
  assign more_col  = col_inc < w;
  assign more_page = page_inc < pc;
  assign nxt_col   = more_col ? col_inc[ColW-1:0] : '0;
  assign nxt_page  = more_col ? scan_page_q : page_inc[PageW-1:0];

  assign row      = {scan_page_q, cmd_i.rd_step[2:0]};
  assign row_base = 11'(row) * 11'(rb);
  assign idx      = row_base + 11'(scan_col_q[ColW-1:3]);
  assign rd_addr  = {cmd_i.rd_step[3], idx[IdxW-1:0]};
  assign wr_addr  = {frame_sel_i, src_index_i};

  assign lin      = 11'(scan_page_q) * 11'(w) + 11'(scan_col_q);
  assign cur_addr = lin[9:0];
  assign cur_byte = cfg_i.diff_mode ? acc1_q : acc0_q;
  assign px       = rdata_q[scan_col_q[2:0]] & rd_ok_q;

  assign sts_o.done_cond = rd_done_q | ({1'b0, rd_page_q} >= pc) | ({1'b0, rd_col_q} >= w);
  assign sts_o.differ    = (acc0_q != acc1_q);
  assign sts_o.more      = more_col | more_page;
  assign sts_o.out_free  = !out_valid_q | out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      store_q[wr_addr] <= src_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_step_q <= 4'd0;
      rd_ok_q   <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_issue;
      rd_step_q <= cmd_i.rd_step;
      rd_ok_q   <= ({1'b0, row} < h);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      if (rd_step_q[3]) begin
        acc1_q[rd_step_q[2:0]] <= px;
      end else begin
        acc0_q[rd_step_q[2:0]] <= px;
      end
    end
    if (cmd_i.hit_save) begin
      hit_addr_q <= cur_addr;
      hit_byte_q <= acc1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_page_q   <= '0;
      rd_col_q    <= '0;
      rd_done_q   <= 1'b0;
      scan_page_q <= '0;
      scan_col_q  <= '0;
    end else begin
      if (cmd_i.restart) begin
        rd_page_q <= '0;
        rd_col_q  <= '0;
        rd_done_q <= 1'b0;
      end else begin
        if (cmd_i.cursor_adv) begin
          rd_page_q <= nxt_page;
          rd_col_q  <= nxt_col;
        end
        if (cmd_i.done_set) begin
          rd_done_q <= 1'b1;
        end
      end
      if (cmd_i.scan_init) begin
        scan_page_q <= rd_page_q;
        scan_col_q  <= rd_col_q;
      end else if (cmd_i.scan_adv) begin
        scan_page_q <= nxt_page;
        scan_col_q  <= nxt_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_last_q <= cmd_i.out_last;
      unique case (cmd_i.out_kind)
        OUT_CUR: begin
          out_addr_q  <= cur_addr;
          out_byte_q  <= cur_byte;
          out_found_q <= 1'b1;
        end
        OUT_HIT: begin
          out_addr_q  <= hit_addr_q;
          out_byte_q  <= hit_byte_q;
          out_found_q <= 1'b1;
        end
        default: begin
          out_addr_q  <= 10'd0;
          out_byte_q  <= 8'd0;
          out_found_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign lcd_addr_o  = out_addr_q;
  assign lcd_byte_o  = out_byte_q;
  assign found_o     = out_found_q;
  assign is_last_o   = out_last_q;

endmodule
`default_nettype wire

### sv/bmlcd_chk.sv
`default_nettype none
module bmlcd_chk import bmlcd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_notfound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 24'd0))
    else $error("not-found result must be last and zero");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == REQ_FETCH) |=> !s_axis_tready)
    else $error("fetch request did not occupy the block");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == REQ_WRITE) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("write request produced a result");

endmodule

bind bitmap_to_lcd_page_bytes_with_diff bmlcd_chk u_chk (.*);
`default_nettype wire

### tb/sv/lcd_page_checker.sv
`timescale 1ns / 100ps
module lcd_page_checker import bmlcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // src_index[9:0], src_byte[17:10], zero pad
  input  logic [2:0]  s_axis_tuser,  // req_type[1:0], frame_sel[2]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // lcd_addr[9:0], lcd_byte[17:10], zero pad
  input  logic [0:0]  m_axis_tuser,  // found[0]
  input  logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors_o,
  output int          pending_o,
  output int          bytes_o,
  output int          exhausted_o
);

  typedef struct packed {
    logic [9:0] addr;
    logic [7:0] data;
    logic       found;
    logic       last;
  } page_out_t;

  logic [7:0]  bitmap_mem [2][FrameBytes];
  page_out_t   lcd_expect_q [$];
  int unsigned width_reg;
  int unsigned height_reg;
  logic        diff_reg;
  int unsigned cur_page;
  int unsigned cur_col;
  logic        readout_over;
  int          errors;
  int          bytes_seen;
  int          exhausted_seen;

  initial begin
    errors = 0;
    bytes_seen = 0;
    exhausted_seen = 0;
    for (int f = 0; f < 2; f++) begin
      for (int i = 0; i < FrameBytes; i++) begin
        bitmap_mem[f][i] = '0;
      end
    end
  end

  function automatic int unsigned cols_used();
    int unsigned w;
    w = (width_reg == 0) ? 1 : width_reg;
    return (w > MaxWidth) ? MaxWidth : w;
  endfunction

  function automatic int unsigned rows_used();
    int unsigned h;
    h = (height_reg == 0) ? 1 : height_reg;
    return (h > MaxHeight) ? MaxHeight : h;
  endfunction

  function automatic int unsigned pages_used();
    return (rows_used() + 7) / 8;
  endfunction

  function automatic logic [7:0] vertical_byte(int unsigned frame, int unsigned page,
                                               int unsigned col);
    int unsigned w;
    int unsigned h;
    int unsigned rb;
    int unsigned row;
    int unsigned idx;
    logic [7:0]  src;
    logic [7:0]  acc;
    w = cols_used();
    h = rows_used();
    rb = (w + 7) / 8;
    acc = '0;
    for (int b = 0; b < 8; b++) begin
      row = page * 8 + b;
      if (row < h && col < w) begin
        idx = row * rb + col / 8;
        src = bitmap_mem[frame][idx % FrameBytes];
        acc[b] = src[col % 8];
      end
    end
    return acc;
  endfunction

  function automatic bit next_address(inout int unsigned page, inout int unsigned col);
    if (col + 1 < cols_used()) begin
      col = col + 1;
      return 1'b1;
    end
    if (page + 1 < pages_used()) begin
      page = page + 1;
      col = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit seek_difference(inout int unsigned page, inout int unsigned col);
    forever begin
      if (vertical_byte(0, page, col) != vertical_byte(1, page, col)) begin
        return 1'b1;
      end
      if (!next_address(page, col)) begin
        return 1'b0;
      end
    end
  endfunction

  function automatic void predict_fetch();
    int unsigned w;
    int unsigned pg;
    int unsigned cl;
    int unsigned np;
    int unsigned nc;
    page_out_t   r;
    w = cols_used();
    r = '0;
    if (cur_page >= pages_used() || cur_col >= w) begin
      readout_over = 1'b1;
    end
    pg = cur_page;
    cl = cur_col;
    if (!readout_over && diff_reg) begin
      if (!seek_difference(pg, cl)) begin
        readout_over = 1'b1;
      end
    end
    if (readout_over) begin
      r.last = 1'b1;
    end else begin
      r.addr = 10'(pg * w + cl);
      r.found = 1'b1;
      r.data = vertical_byte(diff_reg ? 1 : 0, pg, cl);
      np = pg;
      nc = cl;
      if (next_address(np, nc)) begin
        cur_page = np;
        cur_col = nc;
        r.last = diff_reg ? !seek_difference(np, nc) : 1'b0;
      end else begin
        readout_over = 1'b1;
        r.last = 1'b1;
      end
    end
    lcd_expect_q.push_back(r);
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin
    page_out_t want;
    page_out_t got;
    if (!rst_ni) begin
      width_reg = WidthReset;
      height_reg = HeightReset;
      diff_reg = 1'b0;
      cur_page = 0;
      cur_col = 0;
      readout_over = 1'b0;
      lcd_expect_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIDTH:  width_reg = pwdata[7:0];
          REG_HEIGHT: height_reg = pwdata[6:0];
          REG_DIFF:   diff_reg = pwdata[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.addr = m_axis_tdata[9:0];
        got.data = m_axis_tdata[17:10];
        got.found = m_axis_tuser[0];
        got.last = m_axis_tlast;
        if (lcd_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected page byte, expected none, actual addr %0d byte %02h found %0b last %0b",
                   $time, got.addr, got.data, got.found, got.last);
        end else begin
          want = lcd_expect_q.pop_front();
          if (got.addr != want.addr) report_field("lcd_addr", want.addr, got.addr);
          if (got.data != want.data) report_field("lcd_byte", want.data, got.data);
          if (got.found != want.found) report_field("found", want.found, got.found);
          if (got.last != want.last) report_field("is_last", want.last, got.last);
          if (want.found) begin
            bytes_seen++;
          end else begin
            exhausted_seen++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser[1:0])
          REQ_WRITE: begin
            if (s_axis_tdata[9:0] < FrameBytes) begin
              bitmap_mem[s_axis_tuser[2]][s_axis_tdata[9:0]] = s_axis_tdata[17:10];
            end
          end
          REQ_RESTART: begin
            cur_page = 0;
            cur_col = 0;
            readout_over = 1'b0;
          end
          REQ_FETCH: predict_fetch();
          default: ;
        endcase
      end
    end
    errors_o <= errors;
    pending_o <= lcd_expect_q.size();
    bytes_o <= bytes_seen;
    exhausted_o <= exhausted_seen;
  end

endmodule

### tb/sv/tb_bitmap_to_lcd_page_bytes_with_diff.sv
`timescale 1ns / 100ps
module tb_bitmap_to_lcd_page_bytes_with_diff;
  import bmlcd_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CycleLimit = 3000000;
  localparam int RandomItems = 500;
  localparam int FillBytes = 256;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // src_index[9:0], src_byte[17:10], zero pad
  logic [2:0]  s_axis_tuser;  // req_type[1:0], frame_sel[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;  // lcd_addr[9:0], lcd_byte[17:10], zero pad
  logic [0:0]  m_axis_tuser;  // found[0]
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          error_cnt;
  int          pending_cnt;
  int          byte_cnt;
  int          exhausted_cnt;
  int          sent_total = 0;
  int          phase_count = 0;
  int          cycles = 0;
  bit          burst_mode = 1'b0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;

  bitmap_to_lcd_page_bytes_with_diff dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  lcd_page_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .errors_o      (error_cnt),
    .pending_o     (pending_cnt),
    .bytes_o       (byte_cnt),
    .exhausted_o   (exhausted_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d page bytes outstanding.", cycles, pending_cnt);
      $display("tb_bitmap_to_lcd_page_bytes_with_diff NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
    end else if (stall_left != 0) begin
      stall_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll >= 97) begin
        calm_left = $urandom_range(50, 300);
      end else if (roll >= 90) begin
        stall_left = $urandom_range(8, 40);
      end else if (roll >= 60) begin
        stall_left = $urandom_range(1, 3);
      end
    end
    m_axis_tready <= (stall_left == 0);
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [9:0] region_index(int unsigned rows, int unsigned rowb);
    return 10'($urandom_range(0, rows - 1) * rowb + $urandom_range(0, rowb - 1));
  endfunction

  task automatic send_item(input logic [1:0] req, input logic frame,
                           input logic [9:0] idx, input logic [7:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, data, idx};
    s_axis_tuser  <= {frame, req};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (req != REQ_UNUSED) sent_total++;
  endtask

  task automatic send_fetch();
    send_item(REQ_FETCH, 1'($urandom), 10'($urandom), 8'($urandom));
  endtask

  task automatic send_restart();
    send_item(REQ_RESTART, 1'($urandom), 10'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] which, input logic [31:0] value);
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h, input bit dm);
    wait_idle();
    apb_write(REG_WIDTH, 32'(w));
    apb_write(REG_HEIGHT, 32'(h));
    apb_write(REG_DIFF, 32'(dm));
    phase_count++;
  endtask

  task automatic run_phase(input bit big);
    int unsigned w_set;
    int unsigned h_set;
    int unsigned cols;
    int unsigned rows;
    int unsigned rowb;
    int unsigned n_wr;
    int unsigned n_fetch;
    int unsigned roll;
    bit          dm;
    logic        frame;
    dm = 1'($urandom_range(0, 1));
    if (big) begin
      case ($urandom_range(0, 2))
        0: w_set = MaxWidth;
        1: w_set = 255;
        default: w_set = $urandom_range(100, MaxWidth - 1);
      endcase
      // A diff scan may read the whole image, so it stays inside the filled bytes.
      if (dm) begin
        h_set = $urandom_range(9, FillBytes / RowBytesMax);
      end else begin
        case ($urandom_range(0, 2))
          0: h_set = MaxHeight;
          1: h_set = 127;
          default: h_set = $urandom_range(40, MaxHeight - 1);
        endcase
      end
    end else begin
      w_set = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      h_set = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
    end
    set_geometry(w_set, h_set, dm);
    burst_mode = ($urandom_range(0, 3) == 0);
    cols = (w_set == 0) ? 1 : ((w_set > MaxWidth) ? MaxWidth : w_set);
    rows = (h_set == 0) ? 1 : ((h_set > MaxHeight) ? MaxHeight : h_set);
    rowb = (cols + 7) / 8;
    send_restart();
    n_wr = $urandom_range(2, 12);
    for (int k = 0; k < n_wr; k++) begin
      frame = dm ? 1'($urandom_range(0, 3) != 0) : 1'($urandom);
      send_item(REQ_WRITE, frame, region_index(rows, rowb), 8'($urandom));
    end
    if (big) begin
      n_fetch = $urandom_range(20, 40);
    end else if (dm) begin
      n_fetch = $urandom_range(4, 16);
    end else begin
      n_fetch = cols * ((rows + 7) / 8) + $urandom_range(1, 3);
    end
    for (int k = 0; k < n_fetch; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_item(REQ_WRITE, 1'($urandom), 10'($urandom), 8'($urandom));
      end else if (roll < 12) begin
        send_item(REQ_UNUSED, 1'($urandom), 10'($urandom), 8'($urandom));
      end else if (roll < 15 && !big) begin
        send_restart();
      end else if (roll < 25) begin
        frame = dm ? 1'($urandom_range(0, 3) != 0) : 1'($urandom);
        send_item(REQ_WRITE, frame, region_index(rows, rowb), 8'($urandom));
      end
      send_fetch();
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    int unsigned v;
    int          base;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both frames get the same contents over the bytes that every diff-mode geometry reads,
    // so differences come only from later writes.
    for (int i = 0; i < FillBytes; i++) begin
      v = $urandom_range(0, 255);
      send_item(REQ_WRITE, 1'b0, 10'(i), 8'(v));
      send_item(REQ_WRITE, 1'b1, 10'(i), 8'(v));
    end

    send_fetch();
    send_item(REQ_UNUSED, 1'b1, 10'h3FF, 8'hFF);
    send_item(REQ_WRITE, 1'b0, 10'd0, 8'h00);
    send_item(REQ_WRITE, 1'b1, 10'd0, 8'h01);
    send_item(REQ_WRITE, 1'b0, 10'h0FF, 8'h00);
    send_item(REQ_WRITE, 1'b1, 10'h0FF, 8'hFF);
    send_fetch();

    // Full-width diff readout: one change at the first address, eight at the very end.
    set_geometry(MaxWidth, 16, 1'b1);
    send_restart();
    repeat (10) send_fetch();

    set_geometry(0, 0, 1'b1);
    send_restart();
    repeat (2) send_fetch();

    set_geometry(255, 127, 1'b0);
    send_restart();
    repeat (2) send_fetch();

    // Shrinking the width leaves the cursor outside the image.
    set_geometry(2, 127, 1'b0);
    send_fetch();
    send_restart();
    send_fetch();

    base = sent_total;
    while (sent_total - base < RandomItems) begin
      run_phase($urandom_range(0, 9) == 0);
    end
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests under %0d register settings in %0d cycles.",
             sent_total, phase_count, cycles);
    $display("Checked %0d page bytes and %0d end-of-readout answers, %0d mismatches.",
             byte_cnt, exhausted_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("tb_bitmap_to_lcd_page_bytes_with_diff OK");
    end else begin
      $display("tb_bitmap_to_lcd_page_bytes_with_diff NOT OK");
    end
    $finish;
  end

endmodule
